[sv/sdae_pkg.sv]
package sdae_pkg;

  localparam int unsigned MagW      = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned CharW     = 6;

  localparam logic [CntW-1:0]  IterLast  = CntW'(MagW - 1);
  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StScan,
    StSign,
    StEmit
  } state_e;

endpackage

[sv/signed_decimal_ascii_emitter_core.sv]
// An item is converted in StConv (32 passes through the shared shift-add-3 unit), its
// leading digit is found in StScan, then StSign (negative values only) and StEmit load
// its n = 1..11 characters in turn into an output register that holds each character.
// s_axis_tready is high only while idle: no new item until the last character is loaded.
// Reset (rst_ni low, asynchronous) returns to idle with no character pending.
module signed_decimal_ascii_emitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
  output logic        m_axis_tlast    // last_char
);
  import sdae_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MagW-1:0]   mag_q, mag_d;
  bcd_t              bcd_q, bcd_d;
  logic              neg_q, neg_d;
  idx_t              idx_q, idx_d;
  logic              vld_q, vld_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;

  bcd_t              bcd_step;
  idx_t              lead;
  logic              load_out;

  sdae_dabble_step u_step (
    .bcd_i (bcd_q),
    .bit_i (mag_q[MagW-1]),
    .bcd_o (bcd_step)
  );

  sdae_lead_scan u_scan (
    .bcd_i  (bcd_q),
    .lead_o (lead)
  );

  assign load_out      = !vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (s_axis_tvalid) state_d = StConv;
      StConv: if (cnt_q == IterLast) state_d = StScan;
      StScan: state_d = neg_q ? StSign : StEmit;
      StSign: if (load_out) state_d = StEmit;
      StEmit: if (load_out && idx_q == '0) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath and output register
  always_comb begin
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    idx_d  = idx_q;
    vld_d  = vld_q && !m_axis_tready;
    char_d = char_q;
    last_d = last_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          neg_d = s_axis_tdata[MagW-1];
          mag_d = s_axis_tdata[MagW-1] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
          bcd_d = '0;
          cnt_d = '0;
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        mag_d = {mag_q[MagW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      StScan: idx_d = lead;
      StSign: begin
        if (load_out) begin
          vld_d  = 1'b1;
          char_d = CharMinus;
          last_d = 1'b0;
        end
      end
      StEmit: begin
        if (load_out) begin
          vld_d  = 1'b1;
          char_d = CharZero | {2'b00, bcd_q[idx_q]};
          last_d = (idx_q == '0);
          idx_d  = idx_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, char_q};
  assign m_axis_tlast  = last_q;

endmodule

[sv/sdae_dabble_step.sv]
// One shift-add-3 pass: adjust every digit, then shift the next magnitude bit in.
module sdae_dabble_step (
  input  sdae_pkg::bcd_t bcd_i,
  input  logic           bit_i,
  output sdae_pkg::bcd_t bcd_o
);
  import sdae_pkg::*;

  bcd_t adj;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd_i[i] >= 4'd5) ? bcd_i[i] + 4'd3 : bcd_i[i];
    end
  end

  // The top digit never exceeds 4 for a 32-bit magnitude, so its carry-out is dropped.
  assign bcd_o = {adj[NumDigits-1][DigitW-2:0], adj[NumDigits-2:0], bit_i};

endmodule

[sv/sdae_lead_scan.sv]
// Index of the most significant nonzero digit; zero when all digits are zero.
module sdae_lead_scan (
  input  sdae_pkg::bcd_t bcd_i,
  output sdae_pkg::idx_t lead_o
);
  import sdae_pkg::*;

  always_comb begin
    lead_o = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_i[i] != '0) begin
        lead_o = IdxW'(i);
      end
    end
  end

endmodule

[tb/sv/signed_decimal_ascii_emitter_core_tb.sv]
module signed_decimal_ascii_emitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdae_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] value (signed)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [5:0] character, [7:6] zero
  logic        m_axis_tlast;         // last_char

  logic [31:0] pending_values[$];
  text_char_t  expected_chars[$];

  int errors = 0;
  int values_sent = 0;
  int chars_seen = 0;
  int neg_values = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_cyc = 0;
  bit rx_rdy;

  signed_decimal_ascii_emitter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decimal text of one value, most significant digit first, sign in front.
  function automatic void queue_decimal_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digs[NumDigits];
    int          n;
    text_char_t  c;
    mag = v[31] ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != 0 && n < NumDigits);
    if (v[31]) begin
      c.ch = CharMinus;
      c.is_last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch = CharZero + CharW'(digs[i]);
      c.is_last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Random value with a chosen digit count, so every text length shows up.
  function automatic logic [31:0] value_of_length(input int ndig, input bit neg);
    longint unsigned lo, hi;
    logic [31:0] mag;
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = (ndig == 1) ? 9 : lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? (~mag + 32'd1) : mag;
  endfunction

  // Sender: bursts of items with random gaps, some stretches without gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        queue_decimal_text(s_axis_tdata);
        values_sent++;
        if (s_axis_tdata[31]) neg_values++;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_values.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(4, 20);
            default: gap_left = $urandom_range(20, 70);
          endcase
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern plus one long hold-off; checks every character.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cyc++;
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character %0d last %0b", m_axis_tdata[5:0], m_axis_tlast);
          errors++;
        end else begin
          text_char_t e;
          e = expected_chars.pop_front();
          if (m_axis_tdata[5:0] !== e.ch) begin
            $error("character: expected %0d, got %0d", e.ch, m_axis_tdata[5:0]);
            errors++;
          end
          if (m_axis_tlast !== e.is_last) begin
            $error("last_char: expected %0b, got %0b", e.is_last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tdata[7:6] !== 2'b00) begin
            $error("tdata pad: expected 0, got %0d", m_axis_tdata[7:6]);
            errors++;
          end
        end
      end

      if (!hold_done && chars_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rx_rdy = 1'b0;
      end else begin
        case (stall_mode)
          0: rx_rdy = 1'b1;
          1: rx_rdy = 1'($urandom_range(0, 1));
          2: rx_rdy = ($urandom_range(0, 7) == 0);
          default: rx_rdy = (rx_cyc % 5) != 2;
        endcase
      end
      m_axis_tready <= rx_rdy;
    end
  end

  initial begin
    int ndig;
    int kind;
    // directed: zero, unit steps, digit boundaries, both extremes, bit patterns
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'd1234567890);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'd1000000001);
    pending_values.push_back(-32'sd9);

    for (int i = 0; i < 300; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        ndig = $urandom_range(1, NumDigits);
        pending_values.push_back(value_of_length(ndig, 1'($urandom_range(0, 1))));
      end else if (kind < 9) begin
        pending_values.push_back($urandom());
      end else begin
        case ($urandom_range(0, 3))
          0: pending_values.push_back(32'h8000_0000);
          1: pending_values.push_back(32'h7FFF_FFFF);
          2: pending_values.push_back(32'd0);
          default: pending_values.push_back(-32'sd1);
        endcase
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_values.size() == 0 && !s_axis_tvalid);
    wait (expected_chars.size() == 0);
    repeat (60) @(posedge clk_i);

    $display("Converted %0d values (%0d negative), checked %0d characters.",
             values_sent, neg_values, chars_seen);
    $display("Receiver hold-off of 600 cycles %s.", hold_done ? "applied" : "not reached");
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/sdae_pkg.sv
sv/sdae_dabble_step.sv
sv/sdae_lead_scan.sv
sv/signed_decimal_ascii_emitter_core.sv
tb/sv/signed_decimal_ascii_emitter_core_tb.sv
